/* rtl/hma_pkg.sv */
package hma_pkg;

  localparam int MAX_WINDOW      = 64;
  localparam int MAX_ROOT_WINDOW = 8;
  localparam int LEN_W   = 7;
  localparam int LEN_RESET = 9;
  localparam int HA_W    = $clog2(MAX_WINDOW);
  localparam int DA_W    = $clog2(MAX_ROOT_WINDOW);
  localparam int WIN_W   = $clog2(MAX_WINDOW + 1);
  localparam int RWIN_W  = $clog2(MAX_ROOT_WINDOW + 1);
  localparam int X_W     = 32;
  localparam int D_W     = 34;
  localparam int PS_W    = 40;
  localparam int WS_W    = 48;
  localparam int DV_W    = 50;
  localparam int DS_W    = 12;
  localparam int CNT_W   = 8;
  localparam int CNT_CAP = MAX_WINDOW + MAX_ROOT_WINDOW;
  localparam int QDEPTH  = 4;
  localparam int QA_W    = $clog2(QDEPTH);

  typedef struct packed {
    logic                   start;
    logic signed [DV_W-1:0] dvd;
    logic [DS_W-1:0]        dsr;
  } div_req_t;

  typedef struct packed {
    logic                   done;
    logic signed [DV_W-1:0] quo;
    logic [DS_W-1:0]        rem;
  } div_rsp_t;

  function automatic logic [WIN_W-1:0] clamp_full(input logic [LEN_W-1:0] k);
    logic [WIN_W-1:0] res;
    if (k < LEN_W'(2)) res = WIN_W'(2);
    else if (k > LEN_W'(MAX_WINDOW)) res = WIN_W'(MAX_WINDOW);
    else res = WIN_W'(k);
    return res;
  endfunction

  function automatic logic [RWIN_W-1:0] win_root(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] s;
    logic [RWIN_W-1:0] res;
    s = '0;
    for (int i = 1; i < 12; i++) begin
      if (14'(i * i) <= 14'(len)) s = LEN_W'(i);
    end
    if (s < LEN_W'(2)) res = RWIN_W'(2);
    else if (s > LEN_W'(MAX_ROOT_WINDOW)) res = RWIN_W'(MAX_ROOT_WINDOW);
    else res = RWIN_W'(s);
    return res;
  endfunction

  function automatic logic [DS_W-1:0] tri_sum(input logic [WIN_W-1:0] k);
    logic [2*WIN_W-1:0] p;
    p = (2*WIN_W)'(k) * ((2*WIN_W)'(k) + (2*WIN_W)'(1));
    return DS_W'(p >> 1);
  endfunction

endpackage

/* rtl/hma_inq.sv */
module hma_inq (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [hma_pkg::X_W-1:0]    din,
  output logic                       full,
  output logic                       vld,
  output logic [hma_pkg::X_W-1:0]    dout,
  input  logic                       rd
);
  import hma_pkg::*;

  logic [X_W-1:0]  mem_r [QDEPTH];
  logic [QA_W-1:0] wp_r, rp_r;
  logic [QA_W:0]   cnt_r;
  logic            do_wr, do_rd;

  assign full  = (cnt_r == (QA_W+1)'(QDEPTH));
  assign vld   = (cnt_r != '0);
  assign dout  = mem_r[rp_r];
  assign do_wr = push && !full;
  assign do_rd = rd && vld;

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wp_r] <= din;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) wp_r <= wp_r + QA_W'(1);
      if (do_rd) rp_r <= rp_r + QA_W'(1);
      if (do_wr && !do_rd) cnt_r <= cnt_r + (QA_W+1)'(1);
      else if (do_rd && !do_wr) cnt_r <= cnt_r - (QA_W+1)'(1);
    end
  end

endmodule

/* rtl/hma_div.sv */
module hma_div (
  input  logic              clk,
  input  logic              rst_n,
  input  hma_pkg::div_req_t req,
  output hma_pkg::div_rsp_t rsp
);
  import hma_pkg::*;

  localparam int C_W = $clog2(DV_W + 1);

  logic            busy_r, done_r, neg_r;
  logic [C_W-1:0]  cnt_r;
  logic [DV_W-1:0] sh_r;
  logic [DS_W-1:0] rem_r, dsr_r;
  logic [DS_W:0]   rem_sh;
  logic            ge;
  logic [DV_W-1:0] qm;

  assign rem_sh = {rem_r, sh_r[DV_W-1]};
  assign ge     = rem_sh >= {1'b0, dsr_r};
  assign qm     = sh_r;

  always_comb begin
    rsp.done = done_r;
    if (neg_r && rem_r != '0) begin
      rsp.quo = $signed(~qm);
      rsp.rem = dsr_r - rem_r;
    end else if (neg_r) begin
      rsp.quo = $signed(-qm);
      rsp.rem = '0;
    end else begin
      rsp.quo = $signed(qm);
      rsp.rem = rem_r;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      neg_r <= req.dvd[DV_W-1];
      sh_r  <= req.dvd[DV_W-1] ? DV_W'(-req.dvd) : DV_W'(req.dvd);
      rem_r <= '0;
      dsr_r <= req.dsr;
    end else if (busy_r) begin
      rem_r <= ge ? DS_W'(rem_sh - {1'b0, dsr_r}) : DS_W'(rem_sh);
      sh_r  <= {sh_r[DV_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= C_W'(DV_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - C_W'(1);
        if (cnt_r == C_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/hma_core.sv */
module hma_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [hma_pkg::LEN_W-1:0]      cfg_wdata,
  input  logic                           q_vld,
  input  logic [hma_pkg::X_W-1:0]        q_data,
  output logic                           q_rd,
  output hma_pkg::div_req_t              dreq,
  input  hma_pkg::div_rsp_t              drsp,
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic signed [hma_pkg::X_W-1:0] out_hull_value,
  output logic                           out_value_valid
);
  import hma_pkg::*;

  typedef enum logic [9:0] {
    ST_IDLE = 10'b0000000001,
    ST_RDN  = 10'b0000000010,
    ST_RDH  = 10'b0000000100,
    ST_UPD  = 10'b0000001000,
    ST_DIV1 = 10'b0000010000,
    ST_DIV2 = 10'b0000100000,
    ST_DIFF = 10'b0001000000,
    ST_ROOT = 10'b0010000000,
    ST_DIV3 = 10'b0100000000,
    ST_OUT  = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [WIN_W-1:0]  n_r, h_r;
  logic [RWIN_W-1:0] r_r;
  logic [DS_W-1:0]   dn_r, dh_r, dr_r;
  logic [WIN_W-1:0]  n_c, h_c;
  logic [RWIN_W-1:0] r_c;

  logic [X_W-1:0]         hist_mem [MAX_WINDOW];
  logic [MAX_WINDOW-1:0]  hist_vld_r;
  logic [HA_W-1:0]        hp_r, rd_addr;
  logic [X_W-1:0]         rd_data_r;
  logic                   rd_vld_r;

  logic signed [D_W-1:0]  dhist_r [MAX_ROOT_WINDOW];
  logic [DA_W-1:0]        dp_r;

  logic signed [X_W-1:0]  x_r, xn_r, xh_r;
  logic signed [WS_W-1:0] fws_r, hws_r, rws_r;
  logic signed [PS_W-1:0] fps_r, hps_r, rps_r;
  logic signed [WS_W-1:0] fprod, hprod, rprod;
  logic signed [DV_W-1:0] q1_r, q2_r, y_r;
  logic [DS_W-1:0]        r1_r, r2_r;
  logic signed [D_W-1:0]  d_r, dold;
  logic [2*DS_W-1:0]      cross1, cross2;
  logic [CNT_W-1:0]       cnt_r, thr;
  logic                   wait_r, valid_c, fire_out;
  logic signed [X_W-1:0]  sat_c;

  assign n_c = clamp_full(cfg_wdata);
  assign h_c = clamp_full(cfg_wdata >> 1);
  assign r_c = win_root(cfg_wdata);

  assign rd_addr = (state_r == ST_IDLE) ? hp_r - n_r[HA_W-1:0] : hp_r - h_r[HA_W-1:0];
  assign q_rd    = (state_r == ST_IDLE) && q_vld;

  assign fprod  = $signed({1'b0, n_r}) * x_r;
  assign hprod  = $signed({1'b0, h_r}) * x_r;
  assign rprod  = $signed({1'b0, r_r}) * d_r;
  assign dold   = dhist_r[dp_r - r_r[DA_W-1:0]];
  assign cross1 = r1_r * dn_r;
  assign cross2 = r2_r * dh_r;

  assign thr     = CNT_W'(n_r) + CNT_W'(r_r) - CNT_W'(2);
  assign valid_c = cnt_r > thr;
  assign fire_out = (state_r == ST_OUT) && (out_empty || out_pop);

  always_comb begin
    if (y_r > DV_W'(signed'({1'b0, {(X_W-1){1'b1}}}))) sat_c = {1'b0, {(X_W-1){1'b1}}};
    else if (y_r < -(DV_W'(signed'({1'b0, 1'b1, {(X_W-1){1'b0}}}))))
      sat_c = {1'b1, {(X_W-1){1'b0}}};
    else sat_c = y_r[X_W-1:0];
  end

  always_comb begin
    dreq.start = 1'b0;
    dreq.dvd   = {{(DV_W-WS_W){rws_r[WS_W-1]}}, rws_r};
    dreq.dsr   = dr_r;
    case (state_r)
      ST_DIV1: begin
        dreq.start = !wait_r;
        dreq.dvd   = {{(DV_W-WS_W-1){hws_r[WS_W-1]}}, hws_r, 1'b0};
        dreq.dsr   = dh_r;
      end
      ST_DIV2: begin
        dreq.start = !wait_r;
        dreq.dvd   = {{(DV_W-WS_W){fws_r[WS_W-1]}}, fws_r};
        dreq.dsr   = dn_r;
      end
      ST_DIV3: begin
        dreq.start = !wait_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (q_vld) state_nxt = ST_RDN;
      ST_RDN:  state_nxt = ST_RDH;
      ST_RDH:  state_nxt = ST_UPD;
      ST_UPD:  state_nxt = ST_DIV1;
      ST_DIV1: if (drsp.done) state_nxt = ST_DIV2;
      ST_DIV2: if (drsp.done) state_nxt = ST_DIFF;
      ST_DIFF: state_nxt = ST_ROOT;
      ST_ROOT: state_nxt = ST_DIV3;
      ST_DIV3: if (drsp.done) state_nxt = ST_OUT;
      ST_OUT:  if (fire_out) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_UPD) hist_mem[hp_r] <= x_r;
    rd_data_r <= hist_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (q_rd) x_r <= q_data;
    if (state_r == ST_RDN) xn_r <= rd_vld_r ? rd_data_r : '0;
    if (state_r == ST_RDH) xh_r <= rd_vld_r ? rd_data_r : '0;
    if (state_r == ST_DIV1 && drsp.done) begin
      q1_r <= drsp.quo;
      r1_r <= drsp.rem;
    end
    if (state_r == ST_DIV2 && drsp.done) begin
      q2_r <= drsp.quo;
      r2_r <= drsp.rem;
    end
    if (state_r == ST_DIFF) d_r <= D_W'(q1_r - q2_r - ((cross1 < cross2) ? DV_W'(1) : DV_W'(0)));
    if (state_r == ST_DIV3 && drsp.done) y_r <= drsp.quo;
    if (fire_out) begin
      out_hull_value  <= valid_c ? sat_c : '0;
      out_value_valid <= valid_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      wait_r     <= 1'b0;
      out_empty  <= 1'b1;
      n_r        <= clamp_full(LEN_W'(LEN_RESET));
      h_r        <= clamp_full(LEN_W'(LEN_RESET / 2));
      r_r        <= win_root(LEN_W'(LEN_RESET));
      dn_r       <= tri_sum(clamp_full(LEN_W'(LEN_RESET)));
      dh_r       <= tri_sum(clamp_full(LEN_W'(LEN_RESET / 2)));
      dr_r       <= tri_sum(WIN_W'(win_root(LEN_W'(LEN_RESET))));
      hist_vld_r <= '0;
      rd_vld_r   <= 1'b0;
      hp_r       <= '0;
      dp_r       <= '0;
      fws_r      <= '0;
      hws_r      <= '0;
      rws_r      <= '0;
      fps_r      <= '0;
      hps_r      <= '0;
      rps_r      <= '0;
      cnt_r      <= '0;
      for (int i = 0; i < MAX_ROOT_WINDOW; i++) dhist_r[i] <= '0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= hist_vld_r[rd_addr];
      if (dreq.start) wait_r <= 1'b1;
      else if (drsp.done) wait_r <= 1'b0;
      if (fire_out) out_empty <= 1'b0;
      else if (out_pop) out_empty <= 1'b1;
      if (cfg_we) begin
        n_r        <= n_c;
        h_r        <= h_c;
        r_r        <= r_c;
        dn_r       <= tri_sum(n_c);
        dh_r       <= tri_sum(h_c);
        dr_r       <= tri_sum(WIN_W'(r_c));
        hist_vld_r <= '0;
        hp_r       <= '0;
        dp_r       <= '0;
        fws_r      <= '0;
        hws_r      <= '0;
        rws_r      <= '0;
        fps_r      <= '0;
        hps_r      <= '0;
        rps_r      <= '0;
        cnt_r      <= '0;
        for (int i = 0; i < MAX_ROOT_WINDOW; i++) dhist_r[i] <= '0;
      end else begin
        if (state_r == ST_UPD) begin
          fws_r <= fws_r - fps_r + fprod;
          hws_r <= hws_r - hps_r + hprod;
          fps_r <= fps_r - xn_r + x_r;
          hps_r <= hps_r - xh_r + x_r;
          hist_vld_r[hp_r] <= 1'b1;
          hp_r  <= hp_r + HA_W'(1);
        end
        if (state_r == ST_ROOT) begin
          rws_r <= rws_r - rps_r + rprod;
          rps_r <= rps_r - dold + d_r;
          dhist_r[dp_r] <= d_r;
          dp_r  <= dp_r + DA_W'(1);
          if (cnt_r < CNT_W'(CNT_CAP)) cnt_r <= cnt_r + CNT_W'(1);
        end
      end
    end
  end

endmodule

/* rtl/hull_moving_average_filter.sv */
// Streaming Hull moving average over signed Q16.16 prices. Samples enter a
// four-beat queue; the back end handles one sample at a time: it reads the
// history, updates the window sums and runs three floor divisions on one
// shared bit-serial divider. A result waits in an output register while the
// next sample is already being worked on.
// value_valid goes high once more than (N-1)+(R-1) samples have been seen;
// before that hull_value reads 0. Writing window_length restarts the
// history at once (valid bits, no clearing pass) and must happen while idle.
module hull_moving_average_filter (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  output logic                           in_full,
  input  logic signed [hma_pkg::X_W-1:0] in_price_sample,
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic signed [hma_pkg::X_W-1:0] out_hull_value,
  output logic                           out_value_valid,
  input  logic                           cfg_we,
  input  logic [hma_pkg::LEN_W-1:0]      cfg_wdata
);
  import hma_pkg::*;

  logic           q_vld, q_rd;
  logic [X_W-1:0] q_data;
  div_req_t       dreq;
  div_rsp_t       drsp;

  hma_inq u_inq (
    .clk  (clk),
    .rst_n(rst_n),
    .push (in_push),
    .din  (in_price_sample),
    .full (in_full),
    .vld  (q_vld),
    .dout (q_data),
    .rd   (q_rd)
  );

  hma_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (dreq),
    .rsp  (drsp)
  );

  hma_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .q_vld          (q_vld),
    .q_data         (q_data),
    .q_rd           (q_rd),
    .dreq           (dreq),
    .drsp           (drsp),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_hull_value (out_hull_value),
    .out_value_valid(out_value_valid)
  );

endmodule

/* rtl/hma_checker.sv */
module hma_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_full,
  input logic                           out_empty,
  input logic                           out_pop,
  input logic signed [hma_pkg::X_W-1:0] out_hull_value,
  input logic                           out_value_valid
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_hull_value)
      && $stable(out_value_valid))
    else $error("waiting result changed");

  a_warmup_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_value_valid |-> out_hull_value == '0)
    else $error("nonzero value during warm-up");

endmodule

bind hull_moving_average_filter hma_checker u_hma_checker (.*);
